[rtl/smx_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types, constants and helpers for the stereo channel mixer.
// ----------------------------------------------------------------------------
package smx_pkg;

    localparam int CHANNELS = 16;
    localparam int CNT_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam int PROD_W  = 40;
    localparam int ACC_W   = 32;
    localparam int SCALE_W = 27;

    localparam int CH_SHIFT     = 10;
    localparam int MASTER_SHIFT = 21;

    localparam logic [6:0] PAN_FULL  = 7'd127;
    localparam logic [9:0] OUT_MAX   = 10'h3FF;
    localparam logic [9:0] BIAS_INIT = 10'h200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MASTER_ENABLE = 2'd0,
        CFG_MASTER_VOLUME = 2'd1,
        CFG_OUTPUT_BIAS   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic signed [15:0] channel_sample;
        logic [1:0]         divider_select;
        logic [6:0]         volume_factor;
        logic [6:0]         pan_position;
        logic               channel_on;
        logic               last_channel;
    } mix_in_t;

    typedef struct packed {
        logic [9:0] left_out;
        logic [9:0] right_out;
    } mix_out_t;

    // multiplier operand selection
    typedef enum logic [2:0] {
        OP_VOL,
        OP_LEFT,
        OP_RIGHT,
        OP_MLEFT,
        OP_MRIGHT
    } mul_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_L,
        ST_MUL_R,
        ST_ACC_R,
        ST_FIN_L,
        ST_FIN_R,
        ST_FIN_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic    capture;    // take item into datapath, scaled sample computed
        mul_op_t op;
        logic    prod_en;
        logic    acc_l_en;
        logic    acc_r_en;
        logic    fin_left_en;
        logic    out_load;   // load result register, clear accumulators
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;      // result register holds a beat not yet taken
    } dp_status_t;

    // divider select to left shift: div1 4, div2 3, div4 2, div16 0
    function automatic logic [2:0] div_shift(input logic [1:0] sel);
        logic [2:0] sh;
        case (sel)
            2'd0:    sh = 3'd4;
            2'd1:    sh = 3'd3;
            2'd2:    sh = 3'd2;
            default: sh = 3'd0;
        endcase
        return sh;
    endfunction

endpackage
`default_nettype wire

[rtl/smx_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smx_ctrl
// Sequencer for the mixer: walks each channel and each group end through
// the shared multiplier and keeps the channel count.
// ----------------------------------------------------------------------------
module smx_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               item_on,
    input  wire logic               item_last,
    output logic                    in_ready,
    input  wire smx_pkg::dp_status_t status,
    output smx_pkg::dp_cmd_t        cmd
);
    import smx_pkg::*;

    ctrl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             end_reg, end_next;
    logic             accept;
    logic             group_end;

    assign accept    = in_valid && in_ready;
    assign group_end = item_last || (count_reg == CNT_W'(CHANNELS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            end_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            end_reg   <= end_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        end_next   = end_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.op     = OP_VOL;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = accept;
                if (accept)
                begin
                    end_next   = group_end;
                    count_next = group_end ? '0 : count_reg + 1'b1;
                    if (item_on)
                        state_next = ST_MUL_L;
                    else if (group_end)
                        state_next = ST_FIN_L;
                end
            end
            ST_MUL_L:
            begin
                cmd.op      = OP_LEFT;
                cmd.prod_en = 1'b1;
                state_next  = ST_MUL_R;
            end
            ST_MUL_R:
            begin
                cmd.acc_l_en = 1'b1;
                cmd.op       = OP_RIGHT;
                cmd.prod_en  = 1'b1;
                state_next   = ST_ACC_R;
            end
            ST_ACC_R:
            begin
                cmd.acc_r_en = 1'b1;
                state_next   = end_reg ? ST_FIN_L : ST_IDLE;
            end
            ST_FIN_L:
            begin
                cmd.op      = OP_MLEFT;
                cmd.prod_en = 1'b1;
                state_next  = ST_FIN_R;
            end
            ST_FIN_R:
            begin
                cmd.fin_left_en = 1'b1;
                cmd.op          = OP_MRIGHT;
                cmd.prod_en     = 1'b1;
                state_next      = ST_FIN_OUT;
            end
            ST_FIN_OUT:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/smx_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// smx_datapath
// Shared 32x8 signed multiplier, accumulators, master scaling and clip,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module smx_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire smx_pkg::mix_in_t                  in_data,
    input  wire smx_pkg::dp_cmd_t                  cmd,
    output smx_pkg::dp_status_t                    status,
    input  wire logic                              cfg_we,
    input  wire logic [smx_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [smx_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output smx_pkg::mix_out_t                      out_data
);
    import smx_pkg::*;

    logic                      enable_reg;
    logic [6:0]                mvol_reg;
    logic [9:0]                bias_reg;

    logic signed [SCALE_W-1:0] scaled_reg;
    logic [6:0]                pan_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [ACC_W-1:0]          acc_l_reg, acc_l_next;
    logic [ACC_W-1:0]          acc_r_reg, acc_r_next;
    logic [9:0]                fin_left_reg;
    logic                      out_valid_reg;
    mix_out_t                  out_reg;

    logic signed [31:0]        mul_a;
    logic signed [7:0]         mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [ACC_W-1:0]          ch_part;
    logic [9:0]                fin_val;

    // floor shift by 21, add bias, clip to 0..1023
    function automatic logic [9:0] finish(input logic signed [PROD_W-1:0] p,
                                          input logic [9:0] bias);
        logic signed [19:0] v;
        logic [9:0]         r;
        v = 20'($signed(p[PROD_W-1:MASTER_SHIFT])) + $signed({10'd0, bias});
        if (v < 0)
            r = '0;
        else if (v > $signed({10'd0, OUT_MAX}))
            r = OUT_MAX;
        else
            r = v[9:0];
        return r;
    endfunction

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_VOL:
            begin
                mul_a = {{16{in_data.channel_sample[15]}}, in_data.channel_sample}
                        <<< div_shift(in_data.divider_select);
                mul_b = {1'b0, in_data.volume_factor};
            end
            OP_LEFT:
            begin
                mul_a = 32'(scaled_reg);
                mul_b = {1'b0, PAN_FULL - pan_reg};
            end
            OP_RIGHT:
            begin
                mul_a = 32'(scaled_reg);
                mul_b = {1'b0, pan_reg};
            end
            OP_MLEFT:
            begin
                mul_a = acc_l_reg;
                mul_b = {1'b0, mvol_reg};
            end
            OP_MRIGHT:
            begin
                mul_a = acc_r_reg;
                mul_b = {1'b0, mvol_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p   = mul_a * mul_b;
    // product shifted right by 10 (floor), wraps into the 32-bit sum
    assign ch_part = ACC_W'(prod_reg >>> CH_SHIFT);
    assign fin_val = finish(prod_reg, bias_reg);

    always_comb
    begin
        acc_l_next = acc_l_reg;
        acc_r_next = acc_r_reg;
        if (cmd.out_load)
        begin
            acc_l_next = '0;
            acc_r_next = '0;
        end
        else
        begin
            if (cmd.acc_l_en)
                acc_l_next = acc_l_reg + ch_part;
            if (cmd.acc_r_en)
                acc_r_next = acc_r_reg + ch_part;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            mvol_reg      <= '0;
            bias_reg      <= BIAS_INIT;
            acc_l_reg     <= '0;
            acc_r_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MASTER_ENABLE: enable_reg <= cfg_data[0];
                    CFG_MASTER_VOLUME: mvol_reg   <= cfg_data[6:0];
                    CFG_OUTPUT_BIAS:   bias_reg   <= cfg_data[9:0];
                    default:           ;
                endcase
            end
            acc_l_reg <= acc_l_next;
            acc_r_reg <= acc_r_next;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            scaled_reg <= mul_p[SCALE_W-1:0];
            pan_reg    <= in_data.pan_position;
        end
        if (cmd.prod_en)
            prod_reg <= mul_p;
        if (cmd.fin_left_en)
            fin_left_reg <= fin_val;
        if (cmd.out_load)
        begin
            out_reg.left_out  <= enable_reg ? fin_left_reg : '0;
            out_reg.right_out <= enable_reg ? fin_val : '0;
        end
    end

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_reg;

endmodule
`default_nettype wire

[rtl/stereo_channel_mixer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_channel_mixer
// Mixes per-channel samples into one biased, clipped 10-bit stereo sample
// per group of channels.
// ----------------------------------------------------------------------------
//  port group   dir   handshake             payload
//  in_*         in    in_valid / in_ready   mix_in_t   (one channel per beat)
//  out_*        out   out_valid / out_ready mix_out_t  (one beat per group)
//  cfg_*        in    cfg_we, no wait       index + 10-bit data
//
//  An enabled channel is taken in the accept state, which computes
//  sample x volume; ST_MUL_L and ST_MUL_R take left pan and right pan
//  through the single shared 32x8 multiplier, then ST_ACC_R adds the
//  right product. A disabled channel that does not end the group stays idle.
//  A group end adds master scale left, master scale right and result
//  load; the load waits until the previous beat has been taken.
//  Reset clears the accumulators and count; bias resets to 512, master
//  enable and volume to 0. New channels are taken while a result waits.
// ----------------------------------------------------------------------------
module stereo_channel_mixer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire smx_pkg::mix_in_t                in_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output smx_pkg::mix_out_t                    out_data,
    input  wire logic                            cfg_we,
    input  wire logic [smx_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [smx_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import smx_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer: state, channel count, group end
    smx_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .item_on   (in_data.channel_on),
        .item_last (in_data.last_channel),
        .in_ready  (in_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // multiplier, accumulators, config and result register
    smx_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // a pending result beat is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid && !out_ready))
        else $error("result register loaded while beat pending");

    // right accumulate always follows left accumulate
    a_acc_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.acc_l_en |=> cmd.acc_r_en)
        else $error("left accumulate without right");

    // multiplier product register is idle whenever a new channel may enter
    a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !cmd.prod_en)
        else $error("product register busy while accepting");

    // a result beat appears only after a load
    a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
        else $error("result beat without load");

endmodule
`default_nettype wire

[tb/sv/tb_stereo_channel_mixer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_channel_mixer
// Self-checking bench for the stereo channel mixer. A directed table covers
// master off, zero master volume, full-scale samples, every divider, skipped
// channels that end a group, overlong groups and clipping at both ends. A
// random part follows in several register settings. Each channel beat is fed
// to an in-bench mixing model whose stereo outputs are queued and compared,
// field by field, with the beats leaving the block.
// ----------------------------------------------------------------------------
module tb_stereo_channel_mixer;
    import smx_pkg::*;

    localparam int CYCLE_LIMIT     = 1000000;
    localparam int SETTLE_CYCLES   = 12;     // enough for an enabled channel and a group end, with margin
    localparam int DRAIN_CYCLES    = 20;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 178;
    localparam int LONG_HOLD       = 400;
    localparam int REPORT_CAP      = 200;
    localparam int PAN_MAX         = 127;
    localparam int SIDE_SHIFT      = 10;
    localparam int MASTER_SHR      = 21;
    localparam int OUT_CEIL        = 1023;

    typedef enum {ROW_ITEM, ROW_REG} row_kind_t;

    // One line of the directed table: either a register write or a channel
    // beat sent reps times. fixed marks a hand-computed group result.
    typedef struct {
        row_kind_t  kind;
        cfg_index_t reg_idx;
        logic [9:0] reg_val;
        mix_in_t    beat;
        int         reps;
        bit         fixed;
        mix_out_t   want;
    } stim_row_t;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    mix_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    mix_out_t out_data;
    logic     cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // mixing model: register shadow and running sums
    bit          cfg_enable;
    logic [6:0]  cfg_volume;
    logic [9:0]  cfg_bias;
    logic [31:0] left_sum;
    logic [31:0] right_sum;
    int unsigned chans_in_group;

    mix_out_t pending_outputs[$];
    int       mismatches;

    // sender and receiver pacing
    int unsigned burst_left;
    bit          hold_req;
    bit          hold_taken;
    int unsigned hold_left;
    int unsigned rx_mode;
    int unsigned rx_mode_left;
    int unsigned cycle_count;
    mix_out_t    rx_want;

    stereo_channel_mixer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Master scaling of one accumulated side: full-width product, floor
    // shift, bias, then clip into the 10-bit output range.
    function automatic logic [9:0] scale_side(input logic [31:0] acc);
        longint v;
        v = longint'($signed(acc)) * longint'(cfg_volume);
        v = v >>> MASTER_SHR;
        v = v + longint'(cfg_bias);
        if (v < 0)
            v = 0;
        else if (v > OUT_CEIL)
            v = OUT_CEIL;
        return v[9:0];
    endfunction

    // Adds one channel beat to the sums. Returns 1 when the beat closes the
    // group, with the stereo result in res.
    function automatic bit mix_channel(input mix_in_t ch, output mix_out_t res);
        longint smp;
        longint scaled;
        longint lp;
        longint rp;
        int     sh;
        res = '0;
        if (ch.channel_on)
        begin
            case (ch.divider_select)
                2'd0:    sh = 4;
                2'd1:    sh = 3;
                2'd2:    sh = 2;
                default: sh = 0;
            endcase
            smp    = longint'($signed(ch.channel_sample));
            scaled = (smp <<< sh) * longint'(ch.volume_factor);
            // floor shifts: arithmetic shift of a signed 64-bit value
            lp = (scaled * (longint'(PAN_MAX) - longint'(ch.pan_position))) >>> SIDE_SHIFT;
            rp = (scaled * longint'(ch.pan_position)) >>> SIDE_SHIFT;
            left_sum  = left_sum + lp[31:0];
            right_sum = right_sum + rp[31:0];
        end
        chans_in_group++;
        // a group ends on the last mark or when it reaches the channel count
        if (!ch.last_channel && chans_in_group < CHANNELS)
            return 1'b0;
        if (cfg_enable)
        begin
            res.left_out  = scale_side(left_sum);
            res.right_out = scale_side(right_sum);
        end
        left_sum       = '0;
        right_sum      = '0;
        chans_in_group = 0;
        return 1'b1;
    endfunction

    function automatic stim_row_t item_row(input logic signed [15:0] smp,
                                           input logic [1:0] dv,
                                           input logic [6:0] vol,
                                           input logic [6:0] pan,
                                           input bit on, input bit last, input int reps,
                                           input bit fixed,
                                           input logic [9:0] wl, input logic [9:0] wr);
        stim_row_t r;
        r.kind                = ROW_ITEM;
        r.reg_idx             = CFG_MASTER_ENABLE;
        r.reg_val             = '0;
        r.beat.channel_sample = smp;
        r.beat.divider_select = dv;
        r.beat.volume_factor  = vol;
        r.beat.pan_position   = pan;
        r.beat.channel_on     = on;
        r.beat.last_channel   = last;
        r.reps                = reps;
        r.fixed               = fixed;
        r.want.left_out       = wl;
        r.want.right_out      = wr;
        return r;
    endfunction

    function automatic stim_row_t reg_row(input cfg_index_t idx, input logic [9:0] val);
        stim_row_t r;
        r         = item_row(16'sd0, 2'd0, 7'd0, 7'd0, 1'b0, 1'b0, 0, 1'b0, 10'd0, 10'd0);
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // Random channel beat; full-scale samples, full volume and the pan ends
    // come up more often than a flat draw would give them.
    function automatic mix_in_t random_channel(input bit last);
        mix_in_t     b;
        logic [31:0] raw;
        raw = $urandom;
        case ($urandom_range(0, 7))
            0:       b.channel_sample = 16'sh7FFF;
            1:       b.channel_sample = 16'sh8000;
            default: b.channel_sample = raw[15:0];
        endcase
        raw = $urandom;
        b.divider_select = raw[1:0];
        b.volume_factor  = ($urandom_range(0, 7) == 0) ? 7'd127 : raw[8:2];
        case ($urandom_range(0, 9))
            0:       b.pan_position = 7'd0;
            1:       b.pan_position = 7'd127;
            default: b.pan_position = raw[15:9];
        endcase
        b.channel_on   = ($urandom_range(0, 7) != 0);
        b.last_channel = last;
        return b;
    endfunction

    // Offer one channel beat. The sender runs in bursts; between bursts it
    // may drop valid for a random gap. Valid is never dropped while a beat waits.
    task automatic send_channel(input mix_in_t b, input bit fixed, input mix_out_t want);
        int unsigned gap;
        mix_out_t    res;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // beat taken at this edge
        if (mix_channel(b, res))
            pending_outputs.push_back(fixed ? want : res);
    endtask

    // Register write, only once the block has gone quiet: all group results
    // back, then SETTLE_CYCLES more for any channel still in the datapath.
    task automatic write_reg(input cfg_index_t idx, input logic [9:0] val);
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MASTER_ENABLE: cfg_enable = val[0];
            CFG_MASTER_VOLUME: cfg_volume = val[6:0];
            CFG_OUTPUT_BIAS:   cfg_bias   = val;
            default: ;
        endcase
    endtask

    // Output side: checks every beat taken against the oldest expected
    // result and paces out_ready. The stall pattern changes mode now and
    // then (always ready, mostly ready, mostly stalled); one long hold-off
    // is counted here when the stimulus asks for it.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_outputs.size() == 0)
                begin
                    mismatches++;
                    if (mismatches < REPORT_CAP)
                        $display("%0t: unexpected output beat, expected none, actual L=%0d R=%0d",
                                 $time, out_data.left_out, out_data.right_out);
                end
                else
                begin
                    rx_want = pending_outputs.pop_front();
                    if (out_data.left_out !== rx_want.left_out)
                    begin
                        mismatches++;
                        if (mismatches < REPORT_CAP)
                            $display("%0t: left_out mismatch, expected %0d, actual %0d",
                                     $time, rx_want.left_out, out_data.left_out);
                    end
                    if (out_data.right_out !== rx_want.right_out)
                    begin
                        mismatches++;
                        if (mismatches < REPORT_CAP)
                            $display("%0t: right_out mismatch, expected %0d, actual %0d",
                                     $time, rx_want.right_out, out_data.right_out);
                    end
                end
            end

            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD;
            end
            if (rx_mode_left == 0)
            begin
                rx_mode      = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(20, 200);
            end
            rx_mode_left--;

            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    default: out_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles, %0d results outstanding",
                     $time, CYCLE_LIMIT, pending_outputs.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        stim_row_t   rows[$];
        stim_row_t   row;
        mix_out_t    no_want;
        int unsigned phase_items;
        int unsigned glen;
        int unsigned pick;
        logic [9:0]  ph_en;
        logic [9:0]  ph_vol;
        logic [9:0]  ph_bias;

        // everything the block sees is known from time zero
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_ready <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        hold_req  <= 1'b0;

        // model state after reset
        cfg_enable     = 1'b0;
        cfg_volume     = 7'd0;
        cfg_bias       = 10'd512;
        left_sum       = '0;
        right_sum      = '0;
        chans_in_group = 0;
        mismatches     = 0;
        burst_left     = 0;
        hold_taken     = 1'b0;
        hold_left      = 0;
        rx_mode        = 0;
        rx_mode_left   = 0;
        cycle_count    = 0;
        no_want        = '0;

        // Directed table. Fixed results are the ones readable by eye: master
        // off gives zeros, zero master volume gives the bias on both sides,
        // and strongly negative sums with no bias clip to zero.
        // master off out of reset: result forced to zero
        rows.push_back(item_row(16'sh7FFF, 2'd0, 7'd127, 7'd0, 1'b1, 1'b1, 1, 1'b1, 10'd0, 10'd0));
        rows.push_back(item_row(16'sh8000, 2'd3, 7'd127, 7'd127, 1'b1, 1'b1, 1, 1'b1, 10'd0, 10'd0));
        rows.push_back(reg_row(CFG_MASTER_ENABLE, 10'd1));
        // master volume still zero: bias only
        rows.push_back(item_row(16'sd12345, 2'd1, 7'd100, 7'd64, 1'b1, 1'b1, 1, 1'b1,
                                10'd512, 10'd512));
        rows.push_back(reg_row(CFG_MASTER_VOLUME, 10'd127));
        // two full-scale channels, hard left: left side clips high
        rows.push_back(item_row(16'sh7FFF, 2'd0, 7'd127, 7'd0, 1'b1, 1'b0, 1, 1'b0, 10'd0, 10'd0));
        rows.push_back(item_row(16'sh7FFF, 2'd0, 7'd127, 7'd0, 1'b1, 1'b1, 1, 1'b0, 10'd0, 10'd0));
        // most negative sample, hard right
        rows.push_back(item_row(16'sh8000, 2'd0, 7'd127, 7'd127, 1'b1, 1'b1, 1, 1'b0,
                                10'd0, 10'd0));
        // skipped channel still closes its group: empty sums give the bias
        rows.push_back(item_row(-16'sd5, 2'd2, 7'd127, 7'd127, 1'b0, 1'b1, 1, 1'b1,
                                10'd512, 10'd512));
        // remaining dividers, small negative values for the floor shifts
        rows.push_back(item_row(16'sd1000, 2'd1, 7'd64, 7'd32, 1'b1, 1'b0, 1, 1'b0, 10'd0, 10'd0));
        rows.push_back(item_row(-16'sd1000, 2'd2, 7'd1, 7'd1, 1'b1, 1'b0, 1, 1'b0, 10'd0, 10'd0));
        rows.push_back(item_row(-16'sd1, 2'd3, 7'd1, 7'd127, 1'b1, 1'b1, 1, 1'b0, 10'd0, 10'd0));
        // overlong group: the sixteenth unmarked channel closes it
        rows.push_back(item_row(16'sd300, 2'd1, 7'd90, 7'd40, 1'b1, 1'b0, CHANNELS, 1'b0,
                                10'd0, 10'd0));
        // bias at the top with zero master volume
        rows.push_back(reg_row(CFG_MASTER_VOLUME, 10'd0));
        rows.push_back(reg_row(CFG_OUTPUT_BIAS, 10'd1023));
        rows.push_back(item_row(16'sd0, 2'd0, 7'd0, 7'd0, 1'b1, 1'b1, 1, 1'b1,
                                10'd1023, 10'd1023));
        // no bias, large negative sums: both sides clip to zero
        rows.push_back(reg_row(CFG_MASTER_VOLUME, 10'd127));
        rows.push_back(reg_row(CFG_OUTPUT_BIAS, 10'd0));
        rows.push_back(item_row(16'sh8000, 2'd0, 7'd127, 7'd64, 1'b1, 1'b1, 1, 1'b1,
                                10'd0, 10'd0));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            row = rows[i];
            if (row.kind == ROW_REG)
            begin
                write_reg(row.reg_idx, row.reg_val);
            end
            else
            begin
                for (int r = 0; r < row.reps; r++)
                    send_channel(row.beat, row.fixed && (r == row.reps - 1), row.want);
            end
        end

        // Random phases, each under its own register setting. Most traffic
        // is well-formed groups of random length; some groups run to the
        // channel limit unmarked, some carry last marks at random.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    ph_en = 10'd1; ph_vol = 10'd127; ph_bias = 10'd512;
                end
                1:
                begin
                    ph_en = 10'd1; ph_vol = 10'd127; ph_bias = 10'd0;
                end
                2:
                begin
                    ph_en = 10'd1; ph_vol = 10'd127; ph_bias = 10'd1023;
                end
                3:
                begin
                    ph_en = 10'd0; ph_vol = $urandom_range(1, 127);
                    ph_bias = $urandom_range(0, 1023);
                end
                4:
                begin
                    ph_en = 10'd1; ph_vol = 10'd0; ph_bias = $urandom_range(0, 1023);
                end
                default:
                begin
                    ph_en = 10'd1; ph_vol = $urandom_range(1, 126);
                    ph_bias = $urandom_range(0, 1023);
                end
            endcase
            write_reg(CFG_MASTER_ENABLE, ph_en);
            write_reg(CFG_MASTER_VOLUME, ph_vol);
            write_reg(CFG_OUTPUT_BIAS, ph_bias);

            // one long output stall while channels keep coming, so the
            // result register fills and the input backs up
            if (ph == 1)
                hold_req <= 1'b1;

            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                begin
                    glen = CHANNELS;
                    for (int k = 0; k < glen; k++)
                        send_channel(random_channel(1'b0), 1'b0, no_want);
                end
                else if (pick == 1)
                begin
                    glen = $urandom_range(1, 6);
                    for (int k = 0; k < glen; k++)
                        send_channel(random_channel($urandom_range(0, 1)), 1'b0, no_want);
                end
                else
                begin
                    glen = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 16)
                                                       : $urandom_range(1, 8);
                    for (int k = 0; k < glen; k++)
                        send_channel(random_channel(k == glen - 1), 1'b0, no_want);
                end
                phase_items += glen;
            end
            // close any open group before the setting changes
            if (chans_in_group != 0)
                send_channel(random_channel(1'b1), 1'b0, no_want);
        end

        in_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
